// File: hw/rtl/gregorian_date_difference_core_defines.svh
// Assertion helpers for the date difference RTL
`ifndef GREGORIAN_DATE_DIFFERENCE_CORE_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define GDD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gdd_pkg.sv
package gdd_pkg;

   // Reciprocal of 100 and of 400 scaled by 2^21 and 2^23 (same constant)
   localparam logic [14:0] RECIP_HUND    = 15'd20972;
   localparam logic [14:0] DAYS_PER_YEAR = 15'd365;
   localparam int          HUND_LSB      = 21;
   localparam int          FOUR_HUND_LSB = 23;
   localparam int          PROD_W        = 30;

   localparam logic signed [1:0] ORDER_FIRST  = 2'sb01;
   localparam logic signed [1:0] ORDER_SECOND = 2'sb11;
   localparam logic signed [1:0] ORDER_EQUAL  = 2'sb00;

   localparam logic [21:0] SPAN_MAX = 22'h3FFFFF;

   // Sequencer steps of the shared multiplier and accumulator
   typedef enum logic [3:0] {
      STEP_CEIL_L,
      STEP_Q400_L,
      STEP_FLOOR_L,
      STEP_CEIL_E,
      STEP_Q400_E,
      STEP_FLOOR_E,
      STEP_YEARS,
      STEP_ADD_YEARS,
      STEP_ORDINAL
   } step_type;

   typedef struct packed {
      logic     load;
      logic     swap;
      logic     step_en;
      step_type step;
      logic     publish;
   } cmd_type;

   // Leap test from ceil(y/100) and floor(y/100): divisible by 100 when they match
   function automatic logic is_leap_year(input logic [13:0] year,
                                         input logic [8:0]  ceil_hund,
                                         input logic [8:0]  floor_hund);
      is_leap_year = (year[1:0] == 2'b00) &&
                     ((ceil_hund != floor_hund) || (floor_hund[1:0] == 2'b00));
   endfunction

   // Day of year: days of the preceding months plus the day itself, plus one after February in a leap year
   function automatic logic [8:0] ordinal_days(input logic [4:0] day,
                                               input logic [3:0] month,
                                               input logic       leap);
      logic [8:0] base;
      case (month)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         4'd13:   base = 9'd365;
         4'd14:   base = 9'd395;
         default: base = 9'd425;
      endcase
      ordinal_days = {4'b0000, day} + base +
                     ((leap && (month > 4'd2)) ? 9'd1 : 9'd0);
   endfunction

endpackage

// File: hw/rtl/gdd_ctrl.sv
`include "gregorian_date_difference_core_defines.svh"

module gdd_ctrl
   import gdd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWAP,
      S_RUN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one word through swap, the multiply steps and the result register
   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            cmd.swap = 1'b1;
            state_in = S_RUN;
            step_in  = STEP_CEIL_L;
         end
         S_RUN: begin
            cmd.step_en = 1'b1;
            case (step_ff)
               STEP_CEIL_L:    step_in = STEP_Q400_L;
               STEP_Q400_L:    step_in = STEP_FLOOR_L;
               STEP_FLOOR_L:   step_in = STEP_CEIL_E;
               STEP_CEIL_E:    step_in = STEP_Q400_E;
               STEP_Q400_E:    step_in = STEP_FLOOR_E;
               STEP_FLOOR_E:   step_in = STEP_YEARS;
               STEP_YEARS:     step_in = STEP_ADD_YEARS;
               STEP_ADD_YEARS: step_in = STEP_ORDINAL;
               STEP_ORDINAL:   state_in = S_DONE;
               default:        state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            // Publish once the output register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_CEIL_L;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GDD_ASSERT_NEXT(a_accept_to_swap, clock, reset, req_valid && !req_stall, state_ff == S_SWAP, "accepted word did not enter swap")
   `GDD_ASSERT_SAME(a_publish_free, clock, reset, cmd.publish, !rsp_valid_ff || !rsp_stall, "result overwritten while pending")
   `GDD_ASSERT_NEXT(a_last_step_done, clock, reset, (state_ff == S_RUN) && (step_ff == STEP_ORDINAL), state_ff == S_DONE, "sequence did not finish after last step")

endmodule

// File: hw/rtl/gdd_datapath.sv
module gdd_datapath
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = 9999
)
(
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [4:0]         req_first_day,
   input  logic [3:0]         req_first_month,
   input  logic [13:0]        req_first_year,
   input  logic [4:0]         req_second_day,
   input  logic [3:0]         req_second_month,
   input  logic [13:0]        req_second_year,
   output logic [21:0]        rsp_day_span,
   output logic signed [1:0]  rsp_order
);

   localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

   logic [13:0] a_year_c, b_year_c;
   logic [4:0]  a_day_ff, b_day_ff, late_day_ff, early_day_ff;
   logic [3:0]  a_month_ff, b_month_ff, late_month_ff, early_month_ff;
   logic [13:0] a_year_ff, b_year_ff, late_year_ff, early_year_ff;
   logic signed [1:0] order_ff;
   logic        a_gt, a_lt;

   logic [14:0]       mul_a, mul_b;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic [8:0]        q_hund;
   logic [6:0]        q_four_hund;
   logic [8:0]        ceil_ff;
   logic              leap_late_ff, leap_early_ff;
   logic [23:0]       acc_ff;
   logic [14:0]       late_plus3, early_plus3;
   logic [8:0]        ord_late, ord_early;
   logic [23:0]       mag;

   // Clamp years to the configured maximum
   always_comb begin
      a_year_c = ({3'b000, req_first_year} > MaxYearW) ? MaxYearW[13:0] : req_first_year;
      b_year_c = ({3'b000, req_second_year} > MaxYearW) ? MaxYearW[13:0] : req_second_year;
   end

   // Order by year, then month, then day
   assign a_gt = {a_year_ff, a_month_ff, a_day_ff} > {b_year_ff, b_month_ff, b_day_ff};
   assign a_lt = {a_year_ff, a_month_ff, a_day_ff} < {b_year_ff, b_month_ff, b_day_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_day_ff   <= req_first_day;
         a_month_ff <= req_first_month;
         a_year_ff  <= a_year_c;
         b_day_ff   <= req_second_day;
         b_month_ff <= req_second_month;
         b_year_ff  <= b_year_c;
      end
      if (cmd.swap) begin
         order_ff <= a_gt ? ORDER_FIRST : (a_lt ? ORDER_SECOND : ORDER_EQUAL);
         if (a_gt) begin
            late_day_ff    <= a_day_ff;
            late_month_ff  <= a_month_ff;
            late_year_ff   <= a_year_ff;
            early_day_ff   <= b_day_ff;
            early_month_ff <= b_month_ff;
            early_year_ff  <= b_year_ff;
         end else begin
            late_day_ff    <= b_day_ff;
            late_month_ff  <= b_month_ff;
            late_year_ff   <= b_year_ff;
            early_day_ff   <= a_day_ff;
            early_month_ff <= a_month_ff;
            early_year_ff  <= a_year_ff;
         end
      end
   end

   // Select operands of the shared multiplier for each step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_CEIL_L: begin
            mul_a = {1'b0, late_year_ff} + 15'd99;
            mul_b = RECIP_HUND;
         end
         STEP_Q400_L: begin
            mul_a = {1'b0, late_year_ff} + 15'd399;
            mul_b = RECIP_HUND;
         end
         STEP_FLOOR_L: begin
            mul_a = {1'b0, late_year_ff};
            mul_b = RECIP_HUND;
         end
         STEP_CEIL_E: begin
            mul_a = {1'b0, early_year_ff} + 15'd99;
            mul_b = RECIP_HUND;
         end
         STEP_Q400_E: begin
            mul_a = {1'b0, early_year_ff} + 15'd399;
            mul_b = RECIP_HUND;
         end
         STEP_FLOOR_E: begin
            mul_a = {1'b0, early_year_ff};
            mul_b = RECIP_HUND;
         end
         STEP_YEARS: begin
            mul_a = {1'b0, late_year_ff - early_year_ff};
            mul_b = DAYS_PER_YEAR;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in     = mul_a * mul_b;
   assign q_hund      = prod_ff[PROD_W-1:HUND_LSB];
   assign q_four_hund = prod_ff[PROD_W-1:FOUR_HUND_LSB];
   assign late_plus3  = {1'b0, late_year_ff} + 15'd3;
   assign early_plus3 = {1'b0, early_year_ff} + 15'd3;
   assign ord_late    = ordinal_days(late_day_ff, late_month_ff, leap_late_ff);
   assign ord_early   = ordinal_days(early_day_ff, early_month_ff, leap_early_ff);

   // Accumulate the signed day count; every step but the first and the last consumes the previous product
   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         prod_ff <= prod_in;
         case (cmd.step)
            STEP_CEIL_L: begin
               acc_ff <= {11'd0, late_plus3[14:2]} - {11'd0, early_plus3[14:2]};
            end
            STEP_Q400_L: begin
               acc_ff  <= acc_ff - {15'd0, q_hund};
               ceil_ff <= q_hund;
            end
            STEP_FLOOR_L: begin
               acc_ff <= acc_ff + {17'd0, q_four_hund};
            end
            STEP_CEIL_E: begin
               leap_late_ff <= is_leap_year(late_year_ff, ceil_ff, q_hund);
            end
            STEP_Q400_E: begin
               acc_ff  <= acc_ff + {15'd0, q_hund};
               ceil_ff <= q_hund;
            end
            STEP_FLOOR_E: begin
               acc_ff <= acc_ff - {17'd0, q_four_hund};
            end
            STEP_YEARS: begin
               leap_early_ff <= is_leap_year(early_year_ff, ceil_ff, q_hund);
            end
            STEP_ADD_YEARS: begin
               acc_ff <= acc_ff + prod_ff[23:0];
            end
            STEP_ORDINAL: begin
               acc_ff <= acc_ff + {15'd0, ord_late} - {15'd0, ord_early};
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   // Take the magnitude and saturate into the result word
   assign mag = acc_ff[23] ? (24'd0 - acc_ff) : acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_day_span <= (mag[23:22] != 2'b00) ? SPAN_MAX : mag[21:0];
         rsp_order    <= order_ff;
      end
   end

endmodule

// File: hw/rtl/gregorian_date_difference_core.sv
// A request word is accepted in idle, then passes the swap state, the nine steps of the
// single shared multiplier and the publish state before its result word is registered.
// Only one word is in flight: req_stall holds off new requests until it is published.
// A new request is taken while a finished result still waits on rsp_stall.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module gregorian_date_difference_core
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = 9999
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [4:0]        req_first_day,
   input  logic [3:0]        req_first_month,
   input  logic [13:0]       req_first_year,
   input  logic [4:0]        req_second_day,
   input  logic [3:0]        req_second_month,
   input  logic [13:0]       req_second_year,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [21:0]       rsp_day_span,
   output logic signed [1:0] rsp_order
);

   cmd_type cmd;

   gdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gdd_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .rsp_day_span     (rsp_day_span),
      .rsp_order        (rsp_order)
   );

endmodule
